### rtl/core/tts_pkg.sv
// Shared types, codes and sizes of the timed turn queue scheduler.
package tts_pkg;

  // Default sizes handed to the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_USERS_DEF   = 64;

  // Field widths
  localparam int USER_W     = 6;
  localparam int CMD_W      = 3;
  localparam int TIME_W     = 16;
  localparam int QCNT_W     = 5;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  // Width used to range-check user ids against the user count
  localparam int ID_CMP_W   = 10;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURNS_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_LEN = 2'd2;

  // Configuration reset values
  localparam logic              RUNNING_RST  = 1'b0;
  localparam logic              TURNS_EN_RST = 1'b1;
  localparam logic [TIME_W-1:0] TURN_LEN_RST = 16'd20;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_ADV,
    S_SRCH,
    S_SHIFT,
    S_DONE
  } state_t;

  // What the current word asks of the datapath, given the present state
  typedef enum logic [3:0] {
    PLAN_IGNORE,
    PLAN_FULL,
    PLAN_NONE,
    PLAN_TICK,
    PLAN_UNQUEUE,
    PLAN_GRANT,
    PLAN_PUSH_TAIL,
    PLAN_PUSH_FRONT,
    PLAN_ADVANCE,
    PLAN_CLEAR
  } plan_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic adv_pop;
    logic srch_start;
    logic srch_step;
    logic shift_start;
    logic shift_step;
    logic shift_done;
    logic unq_miss;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    plan_t plan;
    logic  q_empty;
    logic  found;
    logic  walk_end;
    logic  out_free;
  } ctl_sts_t;

endpackage

### rtl/core/tts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/tts_ctrl.sv
// Sequencing state machine of the timed turn queue scheduler.
module tts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tts_pkg::ctl_sts_t ctl_sts,
  output tts_pkg::ctl_cmd_t ctl_cmd
);

  tts_pkg::state_t state_r;
  tts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tts_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = tts_pkg::S_DECIDE;
      end
      tts_pkg::S_DECIDE: begin
        if (ctl_sts.plan == tts_pkg::PLAN_UNQUEUE) begin
          state_nxt = tts_pkg::S_SRCH;
        end else if (ctl_sts.plan == tts_pkg::PLAN_ADVANCE && !ctl_sts.q_empty) begin
          state_nxt = tts_pkg::S_ADV;
        end else begin
          state_nxt = tts_pkg::S_DONE;
        end
      end
      tts_pkg::S_ADV: state_nxt = tts_pkg::S_DONE;
      tts_pkg::S_SRCH: begin
        if (ctl_sts.found) begin
          state_nxt = tts_pkg::S_SHIFT;
        end else if (ctl_sts.walk_end) begin
          state_nxt = tts_pkg::S_DECIDE;
        end
      end
      tts_pkg::S_SHIFT: begin
        if (ctl_sts.walk_end) state_nxt = tts_pkg::S_DECIDE;
      end
      tts_pkg::S_DONE: begin
        if (ctl_sts.out_free) state_nxt = tts_pkg::S_IDLE;
      end
      default: state_nxt = tts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl_cmd   = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tts_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        ctl_cmd.load = in_tvalid;
      end
      tts_pkg::S_DECIDE: begin
        if (ctl_sts.plan == tts_pkg::PLAN_UNQUEUE) begin
          ctl_cmd.srch_start = 1'b1;
        end else begin
          ctl_cmd.apply = 1'b1;
        end
      end
      tts_pkg::S_ADV: ctl_cmd.adv_pop = 1'b1;
      tts_pkg::S_SRCH: begin
        if (ctl_sts.found) begin
          ctl_cmd.shift_start = 1'b1;
        end else if (ctl_sts.walk_end) begin
          ctl_cmd.unq_miss = 1'b1;
        end else begin
          ctl_cmd.srch_step = 1'b1;
        end
      end
      tts_pkg::S_SHIFT: begin
        if (ctl_sts.walk_end) begin
          ctl_cmd.shift_done = 1'b1;
        end else begin
          ctl_cmd.shift_step = 1'b1;
        end
      end
      tts_pkg::S_DONE: ctl_cmd.out_load = ctl_sts.out_free;
      default: ctl_cmd = '0;
    endcase
  end

endmodule

### rtl/core/tts_datapath.sv
// Turn holder, wait queue, waiting map, settings and result register.
module tts_datapath #(
  parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_USERS   = tts_pkg::MAX_USERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tts_pkg::IN_DATA_W-1:0]      in_tdata,
  input  tts_pkg::ctl_cmd_t                  ctl_cmd,
  output tts_pkg::ctl_sts_t                  ctl_sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [tts_pkg::OUT_DATA_W-1:0]     out_tdata
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int UIW   = $clog2(MAX_USERS);
  localparam logic [AW-1:0]    LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(QUEUE_DEPTH);
  localparam logic [tts_pkg::ID_CMP_W-1:0] USERS_LIM = tts_pkg::ID_CMP_W'(MAX_USERS);

  // Physical slot of queue position idx, counted from the head
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CNT_W-1:0] idx);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(idx);
    if (sum >= DEPTH_SUM) sum = sum - DEPTH_SUM;
    return AW'(sum);
  endfunction

  // Settings
  logic                        run_r;
  logic                        ten_r;
  logic [tts_pkg::TIME_W-1:0]  tlen_r;

  // Latched item
  logic [tts_pkg::CMD_W-1:0]   cmd_r;
  logic [tts_pkg::USER_W-1:0]  user_r;
  logic                        jack_r;
  logic                        staff_r;

  // Turn and queue state
  logic [tts_pkg::USER_W-1:0]  holder_r;
  logic                        hp_r;
  logic [tts_pkg::TIME_W-1:0]  time_r;
  logic [AW-1:0]               head_r;
  logic [CNT_W-1:0]            count_r;
  logic [MAX_USERS-1:0]        map_r;

  // Queue walk
  logic [CNT_W-1:0]            rd_idx_r;
  logic [CNT_W-1:0]            chk_idx_r;
  logic                        chk_vld_r;

  // Result
  logic                        changed_r;
  logic [tts_pkg::STATUS_W-1:0] res_status_r;
  logic                        out_valid_r;
  logic [tts_pkg::OUT_DATA_W-1:0] out_data_r;

  logic                        user_ok;
  logic                        holder_ok;
  logic [UIW-1:0]              user_slot;
  logic [UIW-1:0]              holder_slot;
  logic                        user_queued;
  logic                        is_holder;
  logic                        q_full;
  logic                        q_empty;
  logic                        walk_more;
  logic                        found;
  logic [AW-1:0]               head_dec;
  logic [AW-1:0]               head_inc;
  logic [CNT_W-1:0]            chk_prev;
  tts_pkg::plan_t              plan;
  logic                        plan_chg;
  logic [tts_pkg::STATUS_W-1:0] plan_status;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [tts_pkg::USER_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [tts_pkg::USER_W-1:0]  ram_rdata;

  tts_ram #(
    .WIDTH (tts_pkg::USER_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign user_ok     = tts_pkg::ID_CMP_W'(user_r) < USERS_LIM;
  assign holder_ok   = tts_pkg::ID_CMP_W'(holder_r) < USERS_LIM;
  assign user_slot   = UIW'(user_r);
  assign holder_slot = UIW'(holder_r);
  assign user_queued = user_ok && map_r[user_slot];
  assign is_holder   = hp_r && (holder_r == user_r);
  assign q_full      = count_r >= DEPTH_CNT;
  assign q_empty     = count_r == '0;
  assign walk_more   = rd_idx_r < count_r;
  assign found       = chk_vld_r && (ram_rdata == user_r);
  assign head_dec    = (head_r == '0) ? LAST_SLOT : head_r - 1'b1;
  assign head_inc    = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign chk_prev    = chk_idx_r - 1'b1;

  always_comb begin
    plan = tts_pkg::PLAN_IGNORE;
    unique case (cmd_r)
      tts_pkg::CMD_REQUEST: begin
        priority if (!(user_ok && run_r && (ten_r || staff_r))) begin
          plan = tts_pkg::PLAN_IGNORE;
        end else if (user_queued && !jack_r) begin
          plan = tts_pkg::PLAN_IGNORE;
        end else if (is_holder) begin
          plan = tts_pkg::PLAN_IGNORE;
        end else if (hp_r && !user_queued && q_full) begin
          plan = tts_pkg::PLAN_FULL;
        end else if (user_queued) begin
          plan = tts_pkg::PLAN_UNQUEUE;
        end else if (!hp_r) begin
          plan = tts_pkg::PLAN_GRANT;
        end else if (!jack_r) begin
          plan = tts_pkg::PLAN_PUSH_TAIL;
        end else begin
          plan = tts_pkg::PLAN_PUSH_FRONT;
        end
      end
      tts_pkg::CMD_END: begin
        priority if (!user_ok) begin
          plan = tts_pkg::PLAN_IGNORE;
        end else if (user_queued) begin
          plan = tts_pkg::PLAN_UNQUEUE;
        end else if (is_holder) begin
          plan = tts_pkg::PLAN_ADVANCE;
        end else begin
          plan = tts_pkg::PLAN_IGNORE;
        end
      end
      tts_pkg::CMD_NEXT:  plan = tts_pkg::PLAN_ADVANCE;
      tts_pkg::CMD_CLEAR: plan = tts_pkg::PLAN_CLEAR;
      tts_pkg::CMD_TICK: begin
        priority if (!hp_r) begin
          plan = tts_pkg::PLAN_NONE;
        end else if (time_r <= tts_pkg::TIME_W'(1)) begin
          plan = tts_pkg::PLAN_ADVANCE;
        end else begin
          plan = tts_pkg::PLAN_TICK;
        end
      end
      default: plan = tts_pkg::PLAN_IGNORE;
    endcase
  end

  always_comb begin
    plan_chg    = 1'b0;
    plan_status = tts_pkg::STAT_DONE;
    unique case (plan)
      tts_pkg::PLAN_IGNORE: begin
        // an end that already pulled the user from the queue counts as done
        plan_status = changed_r ? tts_pkg::STAT_DONE : tts_pkg::STAT_IGNORED;
      end
      tts_pkg::PLAN_FULL: plan_status = tts_pkg::STAT_FULL;
      tts_pkg::PLAN_NONE, tts_pkg::PLAN_TICK, tts_pkg::PLAN_UNQUEUE: begin
        plan_chg = 1'b0;
      end
      tts_pkg::PLAN_GRANT, tts_pkg::PLAN_PUSH_TAIL, tts_pkg::PLAN_PUSH_FRONT,
      tts_pkg::PLAN_ADVANCE, tts_pkg::PLAN_CLEAR: begin
        plan_chg = 1'b1;
      end
      default: plan_status = tts_pkg::STAT_IGNORED;
    endcase
  end

  // Head is read while a plan is applied, for the pop of an advance; otherwise the walk index
  assign ram_raddr = ctl_cmd.apply ? head_r : slot_of(head_r, rd_idx_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(head_r, chk_prev);
    ram_wdata = ram_rdata;
    priority if (ctl_cmd.apply && plan == tts_pkg::PLAN_PUSH_TAIL) begin
      ram_we    = 1'b1;
      ram_waddr = slot_of(head_r, count_r);
      ram_wdata = user_r;
    end else if (ctl_cmd.apply && plan == tts_pkg::PLAN_PUSH_FRONT) begin
      ram_we    = 1'b1;
      ram_waddr = head_dec;
      ram_wdata = holder_r;
    end else if (ctl_cmd.shift_step && chk_vld_r) begin
      ram_we = 1'b1;
    end else begin
      ram_we = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= tts_pkg::RUNNING_RST;
      ten_r       <= tts_pkg::TURNS_EN_RST;
      tlen_r      <= tts_pkg::TURN_LEN_RST;
      holder_r    <= '0;
      hp_r        <= 1'b0;
      time_r      <= '0;
      head_r      <= '0;
      count_r     <= '0;
      map_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tts_pkg::CFG_RUNNING:  run_r  <= cfg_data[0];
          tts_pkg::CFG_TURNS_EN: ten_r  <= cfg_data[0];
          tts_pkg::CFG_TURN_LEN: tlen_r <= cfg_data[tts_pkg::TIME_W-1:0];
          default: run_r <= run_r;
        endcase
      end

      if (ctl_cmd.apply) begin
        unique case (plan)
          tts_pkg::PLAN_GRANT: begin
            holder_r <= user_r;
            hp_r     <= 1'b1;
            time_r   <= tlen_r;
          end
          tts_pkg::PLAN_PUSH_TAIL: begin
            count_r          <= count_r + 1'b1;
            map_r[user_slot] <= 1'b1;
          end
          tts_pkg::PLAN_PUSH_FRONT: begin
            head_r   <= head_dec;
            count_r  <= count_r + 1'b1;
            if (holder_ok) map_r[holder_slot] <= 1'b1;
            holder_r <= user_r;
            time_r   <= tlen_r;
          end
          tts_pkg::PLAN_ADVANCE: begin
            // empty queue frees the turn; otherwise the pop follows
            if (q_empty) begin
              hp_r   <= 1'b0;
              time_r <= '0;
            end
          end
          tts_pkg::PLAN_CLEAR: begin
            count_r <= '0;
            map_r   <= '0;
            hp_r    <= 1'b0;
            time_r  <= '0;
          end
          tts_pkg::PLAN_TICK: time_r <= time_r - 1'b1;
          default: hp_r <= hp_r;
        endcase
      end

      if (ctl_cmd.adv_pop) begin
        holder_r <= ram_rdata;
        hp_r     <= 1'b1;
        time_r   <= tlen_r;
        head_r   <= head_inc;
        count_r  <= count_r - 1'b1;
        if (tts_pkg::ID_CMP_W'(ram_rdata) < USERS_LIM) map_r[UIW'(ram_rdata)] <= 1'b0;
      end

      if (ctl_cmd.srch_start || ctl_cmd.shift_start) begin
        chk_vld_r <= 1'b0;
      end else if (ctl_cmd.srch_step || ctl_cmd.shift_step) begin
        chk_vld_r <= walk_more;
      end

      if (ctl_cmd.shift_done) begin
        count_r          <= count_r - 1'b1;
        map_r[user_slot] <= 1'b0;
      end
      if (ctl_cmd.unq_miss) begin
        map_r[user_slot] <= 1'b0;
      end

      if (ctl_cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (ctl_cmd.load) begin
      cmd_r     <= in_tdata[tts_pkg::CMD_W-1:0];
      user_r    <= in_tdata[tts_pkg::CMD_W +: tts_pkg::USER_W];
      jack_r    <= in_tdata[tts_pkg::CMD_W + tts_pkg::USER_W];
      staff_r   <= in_tdata[tts_pkg::CMD_W + tts_pkg::USER_W + 1];
      changed_r <= 1'b0;
    end else if (ctl_cmd.shift_done) begin
      changed_r <= 1'b1;
    end else if (ctl_cmd.apply) begin
      changed_r <= changed_r | plan_chg;
    end

    if (ctl_cmd.apply) begin
      res_status_r <= plan_status;
    end

    if (ctl_cmd.srch_start) begin
      rd_idx_r <= '0;
    end else if (ctl_cmd.shift_start) begin
      rd_idx_r <= chk_idx_r + 1'b1;
    end else if ((ctl_cmd.srch_step || ctl_cmd.shift_step) && walk_more) begin
      chk_idx_r <= rd_idx_r;
      rd_idx_r  <= rd_idx_r + 1'b1;
    end

    if (ctl_cmd.out_load) begin
      out_data_r <= tts_pkg::OUT_DATA_W'({res_status_r,
                                         changed_r,
                                         hp_r ? time_r : tts_pkg::TIME_W'(0),
                                         tts_pkg::QCNT_W'(count_r),
                                         hp_r ? holder_r : tts_pkg::USER_W'(0),
                                         hp_r});
    end
  end

  assign ctl_sts.plan     = plan;
  assign ctl_sts.q_empty  = q_empty;
  assign ctl_sts.found    = found;
  assign ctl_sts.walk_end = !chk_vld_r && !walk_more;
  assign ctl_sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_map_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(map_r) == int'(count_r))
    else $error("waiting map population differs from queue count");

  a_free_turn_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    !hp_r |-> time_r == '0)
    else $error("time left while nobody holds the turn");

  a_holder_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    hp_r && holder_ok |-> !map_r[holder_slot])
    else $error("turn holder also marked as waiting");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.adv_pop |-> !q_empty)
    else $error("pop from an empty queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.apply && (plan == tts_pkg::PLAN_PUSH_TAIL || plan == tts_pkg::PLAN_PUSH_FRONT)
    |-> !q_full)
    else $error("push into a full queue");

endmodule

### rtl/core/timed_turn_queue_scheduler.sv
// Top level of the timed turn queue scheduler: controller plus datapath.
//
//   port group   dir   handshake              payload
//   in_*         in    in_tvalid/in_tready    in_tdata: command word
//   out_*        out   out_tvalid/out_tready  out_tdata: state snapshot word
//   cfg_*        in    cfg_we (no wait)       cfg_index, cfg_data
//
// Steps: a plain word is latched, then decided and applied, then its result is
// loaded; an advance that pops the queue adds a step for the queue RAM read.
// Removing a queued user walks the queue RAM one entry per cycle up to it,
// then moves the later entries down one per cycle and decides the word again.
// Reset (rst_n low, synchronous) empties queue and turn at once; no clearing
// pass. A stalled result holds in the output register while the next input
// word is taken.
module timed_turn_queue_scheduler #(
  parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_USERS   = tts_pkg::MAX_USERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [2:0] cmd, [8:3] user_id, [9] turn_jack, [10] is_staff, [15:11] zero
  input  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata,
  // result words
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] holder_valid, [6:1] holder_id, [11:7] queue_count, [27:12] ticks_left,
  // [28] changed, [30:29] status, [31] zero
  output logic [tts_pkg::OUT_DATA_W-1:0] out_tdata
);

  tts_pkg::ctl_cmd_t ctl_cmd;
  tts_pkg::ctl_sts_t ctl_sts;

  // Sequence each word: latch, decide, then walk or pop as needed
  tts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .ctl_sts   (ctl_sts),
    .ctl_cmd   (ctl_cmd)
  );

  // Hold turn, queue RAM, waiting map, settings and the result register
  tts_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_USERS   (MAX_USERS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .ctl_cmd    (ctl_cmd),
    .ctl_sts    (ctl_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench of the timed turn queue scheduler: directed table, then random words.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH       = tts_pkg::QUEUE_DEPTH_DEF;
  localparam int USERS       = tts_pkg::MAX_USERS_DEF;
  // receiver hold-off long enough to back the block up into its input
  localparam int HOLD_CYCLES = 200;
  // cycles with no word moving on either side before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // worst removal walks the queue once, plus decide and load cycles
  localparam int DRAIN_WAIT  = 3 * DEPTH + 10;

  typedef logic [tts_pkg::CMD_W-1:0]      cmd_t;
  typedef logic [tts_pkg::USER_W-1:0]     user_t;
  typedef logic [tts_pkg::QCNT_W-1:0]     qcnt_t;
  typedef logic [tts_pkg::TIME_W-1:0]     ticks_t;
  typedef logic [tts_pkg::STATUS_W-1:0]   stat_t;
  typedef logic [tts_pkg::CFG_IDX_W-1:0]  cidx_t;
  typedef logic [tts_pkg::CFG_DATA_W-1:0] cval_t;

  // command codes that the block must ignore
  localparam cmd_t CMD_BAD_LO = 3'd5;
  localparam cmd_t CMD_BAD_HI = 3'd7;

  typedef enum logic { MIX_TURNS, MIX_CROWD } mix_t;

  // one result word, unpacked
  typedef struct packed {
    logic   holder_valid;
    user_t  holder_id;
    qcnt_t  queue_count;
    ticks_t ticks_left;
    logic   changed;
    stat_t  status;
  } snap_t;

  // one row of the directed table: a register write or an input word
  typedef struct {
    bit    is_cfg;
    cidx_t idx;
    cval_t val;
    cmd_t  cmd;
    user_t user;
    bit    jack;
    bit    staff;
    bit    typed;
    snap_t want;
  } row_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_we     = 1'b0;
  cidx_t                          cfg_index  = '0;
  cval_t                          cfg_data   = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  // [2:0] cmd, [8:3] user_id, [9] turn_jack, [10] is_staff, [15:11] zero
  logic [tts_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [0] holder_valid, [6:1] holder_id, [11:7] queue_count, [27:12] ticks_left,
  // [28] changed, [30:29] status, [31] zero
  logic [tts_pkg::OUT_DATA_W-1:0] out_tdata;

  timed_turn_queue_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Turn model: own copy of the registers and of the turn and queue state
  // ---------------------------------------------------------------------------
  logic   cfg_running  = tts_pkg::RUNNING_RST;
  logic   cfg_turns_on = tts_pkg::TURNS_EN_RST;
  ticks_t cfg_turn_len = tts_pkg::TURN_LEN_RST;

  user_t  cur_holder = '0;
  logic   holder_on  = 1'b0;
  user_t  wait_line [DEPTH];
  int     wait_len   = 0;
  bit     in_line [USERS];
  ticks_t turn_left  = '0;

  // Hand the turn to the queue head, or free it when nobody waits.
  function automatic void pass_turn();
    int i;
    if (wait_len > 0) begin
      cur_holder = wait_line[0];
      for (i = 0; i < wait_len - 1; i++) wait_line[i] = wait_line[i + 1];
      wait_len--;
      in_line[cur_holder] = 1'b0;
      holder_on = 1'b1;
      turn_left = cfg_turn_len;
    end else begin
      holder_on = 1'b0;
      turn_left = '0;
    end
  endfunction

  // Pull a user out of the queue, closing the gap; report whether it was there.
  function automatic bit drop_waiter(user_t u);
    int i;
    int j;
    for (i = 0; i < wait_len; i++) begin
      if (wait_line[i] == u) begin
        for (j = i; j < wait_len - 1; j++) wait_line[j] = wait_line[j + 1];
        wait_len--;
        in_line[u] = 1'b0;
        return 1'b1;
      end
    end
    in_line[u] = 1'b0;
    return 1'b0;
  endfunction

  // Apply one input word to the model state and return the snapshot it yields.
  function automatic snap_t turn_step(cmd_t cmd, user_t u, bit jack, bit staff);
    snap_t r;
    bit    ok;
    bit    queued;
    logic  chg;
    stat_t st;
    int    i;
    chg = 1'b0;
    st  = tts_pkg::STAT_IGNORED;
    case (cmd)
      tts_pkg::CMD_REQUEST: begin
        ok     = cfg_running && (cfg_turns_on || staff);
        queued = ok && in_line[u];
        // queued without jack, or already holding: nothing to do
        if (ok && queued && !jack) ok = 1'b0;
        if (ok && holder_on && cur_holder == u) ok = 1'b0;
        if (ok) begin
          if (holder_on && !queued && wait_len >= DEPTH) begin
            st = tts_pkg::STAT_FULL;
          end else begin
            if (queued) void'(drop_waiter(u));
            if (!holder_on) begin
              cur_holder = u;
              holder_on  = 1'b1;
              turn_left  = cfg_turn_len;
            end else if (!jack) begin
              wait_line[wait_len] = u;
              wait_len++;
              in_line[u] = 1'b1;
            end else begin
              // displaced holder goes back to the front of the line
              for (i = wait_len; i > 0; i--) wait_line[i] = wait_line[i - 1];
              wait_line[0] = cur_holder;
              wait_len++;
              in_line[cur_holder] = 1'b1;
              cur_holder = u;
              turn_left  = cfg_turn_len;
            end
            chg = 1'b1;
            st  = tts_pkg::STAT_DONE;
          end
        end
      end
      tts_pkg::CMD_END: begin
        if (in_line[u]) begin
          if (drop_waiter(u)) chg = 1'b1;
        end
        if (holder_on && cur_holder == u) begin
          pass_turn();
          chg = 1'b1;
        end
        if (chg) st = tts_pkg::STAT_DONE;
      end
      tts_pkg::CMD_NEXT: begin
        pass_turn();
        chg = 1'b1;
        st  = tts_pkg::STAT_DONE;
      end
      tts_pkg::CMD_CLEAR: begin
        wait_len = 0;
        foreach (in_line[k]) in_line[k] = 1'b0;
        holder_on = 1'b0;
        turn_left = '0;
        chg = 1'b1;
        st  = tts_pkg::STAT_DONE;
      end
      tts_pkg::CMD_TICK: begin
        st = tts_pkg::STAT_DONE;
        if (holder_on) begin
          // a zero turn length expires on the first tick
          if (turn_left > 0) turn_left--;
          if (turn_left == 0) begin
            pass_turn();
            chg = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.holder_valid = holder_on;
    r.holder_id    = holder_on ? cur_holder : '0;
    r.queue_count  = wait_len[tts_pkg::QCNT_W-1:0];
    r.ticks_left   = holder_on ? turn_left : '0;
    r.changed      = chg;
    r.status       = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table helpers
  // ---------------------------------------------------------------------------
  row_t script [$];

  function automatic snap_t mk_snap(logic hv, user_t id, qcnt_t qc, ticks_t t, logic ch,
                                    stat_t st);
    snap_t r;
    r.holder_valid = hv;
    r.holder_id    = id;
    r.queue_count  = qc;
    r.ticks_left   = t;
    r.changed      = ch;
    r.status       = st;
    return r;
  endfunction

  function automatic row_t word_row(cmd_t c, user_t u, bit j, bit s);
    row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.cmd    = c;
    r.user   = u;
    r.jack   = j;
    r.staff  = s;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic row_t typed_row(cmd_t c, user_t u, bit j, bit s, snap_t w);
    row_t r;
    r       = word_row(c, u, j, s);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic row_t cfg_row(cidx_t i, cval_t v);
    row_t r;
    r        = word_row(tts_pkg::CMD_TICK, '0, 1'b0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = i;
    r.val    = v;
    return r;
  endfunction

  // Append one row to the end of the table.
  function automatic void add_row(row_t r);
    script.insert(script.size(), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  snap_t snap_q [$];      // snapshots still owed by the block, oldest first
  int    fail_n     = 0;
  int    burst_left = 0;
  bit    calm       = 1'b0; // no gaps, no stalls
  bit    hold_req   = 1'b0; // ask the receiver for one long hold-off

  // Offer one word, hold it until taken, then log the snapshot it must produce.
  task automatic send_word(cmd_t c, user_t u, bit j, bit s, bit typed, snap_t want);
    snap_t guess;
    if (!calm && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(tts_pkg::IN_DATA_W - 11){1'b0}}, s, j, u, c};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) burst_left--;
    guess = turn_step(c, u, j, s);
    snap_q.insert(snap_q.size(), typed ? want : guess);
  endtask

  // Drain the block, then write one register.
  task automatic cfg_write(cidx_t idx, cval_t val);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (snap_q.size() != 0);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tts_pkg::CFG_RUNNING:  cfg_running  = val[0];
      tts_pkg::CFG_TURNS_EN: cfg_turns_on = val[0];
      tts_pkg::CFG_TURN_LEN: cfg_turn_len = val[tts_pkg::TIME_W-1:0];
      default: ;
    endcase
    burst_left = $urandom_range(1, 16);
  endtask

  // Random words. The turns mix keeps a small user pool and ticks the turn
  // along; the crowd mix is request heavy over all users to fill the queue.
  task automatic run_phase(mix_t mix, int count);
    cmd_t  c;
    user_t u;
    int    r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (mix == MIX_CROWD) begin
        if      (r < 80) c = tts_pkg::CMD_REQUEST;
        else if (r < 88) c = tts_pkg::CMD_END;
        else if (r < 92) c = tts_pkg::CMD_TICK;
        else if (r < 94) c = tts_pkg::CMD_CLEAR;
        else if (r < 97) c = tts_pkg::CMD_NEXT;
        else             c = cmd_t'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        u = user_t'($urandom_range(0, USERS - 1));
      end else begin
        if      (r < 40) c = tts_pkg::CMD_REQUEST;
        else if (r < 55) c = tts_pkg::CMD_END;
        else if (r < 60) c = tts_pkg::CMD_NEXT;
        else if (r < 62) c = tts_pkg::CMD_CLEAR;
        else if (r < 95) c = tts_pkg::CMD_TICK;
        else             c = cmd_t'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
        u = ($urandom_range(0, 3) == 0) ? user_t'($urandom_range(0, USERS - 1))
                                        : user_t'($urandom_range(0, 7));
      end
      send_word(c, u, $urandom_range(0, 5) == 0, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // -- block stopped after reset: requests ignored, other commands act
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd5, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd63, 1'b1, 1'b1,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    // tick with nobody holding
    add_row(typed_row(tts_pkg::CMD_TICK, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_DONE)));
    add_row(typed_row(tts_pkg::CMD_NEXT, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b1, tts_pkg::STAT_DONE)));
    // unknown commands
    add_row(typed_row(CMD_BAD_LO, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    add_row(typed_row(CMD_BAD_HI, 6'd63, 1'b1, 1'b1,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    // end by a user neither queued nor holding
    add_row(typed_row(tts_pkg::CMD_END, 6'd9, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    add_row(cfg_row(tts_pkg::CFG_RUNNING, 16'd1));
    // grant a free turn, then refuse the holder asking again
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b1, 6'd0, 5'd0, 16'd20, 1'b1, tts_pkg::STAT_DONE)));
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b1, 6'd0, 5'd0, 16'd20, 1'b0, tts_pkg::STAT_IGNORED)));
    add_row(word_row(tts_pkg::CMD_REQUEST, 6'd63, 1'b0, 1'b0)); // join tail
    add_row(word_row(tts_pkg::CMD_REQUEST, 6'd63, 1'b0, 1'b0)); // queued, no jack
    add_row(word_row(tts_pkg::CMD_REQUEST, 6'd21, 1'b1, 1'b0)); // jack from outside
    add_row(word_row(tts_pkg::CMD_REQUEST, 6'd63, 1'b1, 1'b0)); // jack from the queue
    add_row(word_row(tts_pkg::CMD_TICK,    6'd0,  1'b0, 1'b0));
    add_row(word_row(tts_pkg::CMD_END,     6'd0,  1'b0, 1'b0)); // leave the queue
    add_row(word_row(tts_pkg::CMD_END,     6'd40, 1'b0, 1'b0)); // nothing to end
    add_row(word_row(tts_pkg::CMD_END,     6'd63, 1'b0, 1'b0)); // holder ends
    add_row(word_row(tts_pkg::CMD_NEXT,    6'd0,  1'b0, 1'b0));
    add_row(typed_row(tts_pkg::CMD_CLEAR, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b1, tts_pkg::STAT_DONE)));
    // turns off: only staff gets through
    add_row(cfg_row(tts_pkg::CFG_TURNS_EN, 16'd0));
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd10, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_IGNORED)));
    add_row(typed_row(tts_pkg::CMD_REQUEST, 6'd10, 1'b0, 1'b1,
            mk_snap(1'b1, 6'd10, 5'd0, 16'd20, 1'b1, tts_pkg::STAT_DONE)));
    // shortest turn: every tick passes it on
    add_row(cfg_row(tts_pkg::CFG_TURN_LEN, 16'd1));
    add_row(word_row(tts_pkg::CMD_REQUEST, 6'd11, 1'b1, 1'b1));
    add_row(word_row(tts_pkg::CMD_TICK,    6'd0,  1'b0, 1'b0));
    add_row(word_row(tts_pkg::CMD_TICK,    6'd0,  1'b0, 1'b0));
    add_row(typed_row(tts_pkg::CMD_TICK, 6'd0, 1'b0, 1'b0,
            mk_snap(1'b0, 6'd0, 5'd0, 16'd0, 1'b0, tts_pkg::STAT_DONE)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) cfg_write(script[i].idx, script[i].val);
      else send_word(script[i].cmd, script[i].user, script[i].jack, script[i].staff,
                     script[i].typed, script[i].want);
    end

    // -- random part, register settings changed between phases
    cfg_write(tts_pkg::CFG_TURNS_EN, 16'd1);
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'd3);
    run_phase(MIX_TURNS, 400);

    // longest turn, crowd fills the queue; receiver backs up the block meanwhile
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'hFFFF);
    hold_req = 1'b1;
    run_phase(MIX_CROWD, 250);

    cfg_write(tts_pkg::CFG_TURNS_EN, 16'd0);
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'd1);
    run_phase(MIX_TURNS, 300);

    // zero turn length: expires on the first tick
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'd0);
    run_phase(MIX_TURNS, 150);

    // stopped: requests drop, next/clear/tick still act
    cfg_write(tts_pkg::CFG_RUNNING, 16'd0);
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'd2);
    run_phase(MIX_TURNS, 150);

    // full speed stretch with no idling
    cfg_write(tts_pkg::CFG_RUNNING, 16'd1);
    cfg_write(tts_pkg::CFG_TURNS_EN, 16'd1);
    cfg_write(tts_pkg::CFG_TURN_LEN, 16'hFFFF);
    calm = 1'b1;
    run_phase(MIX_TURNS, 300);
    calm = 1'b0;

    cfg_write(tts_pkg::CFG_TURN_LEN, 16'd5);
    run_phase(MIX_CROWD, 300);

    // -- wind down: let every owed word arrive, then watch for strays
    in_tvalid <= 1'b0;
    while (snap_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_n == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random ready runs, one long hold-off on request
  // ---------------------------------------------------------------------------
  bit rdy_now = 1'b0;
  int rdy_run = 0;

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        rdy_run  = 0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        if (rdy_run == 0) begin
          rdy_now = !rdy_now;
          rdy_run = rdy_now ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        rdy_run--;
        out_tready <= rdy_now;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  snap_t want_w;

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_n++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (snap_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_tdata);
        fail_n++;
      end else begin
        want_w = snap_q[0];
        snap_q.delete(0);
        check_field("holder_valid", 32'(want_w.holder_valid), 32'(out_tdata[0]));
        check_field("holder_id",    32'(want_w.holder_id),    32'(out_tdata[6:1]));
        check_field("queue_count",  32'(want_w.queue_count),  32'(out_tdata[11:7]));
        check_field("ticks_left",   32'(want_w.ticks_left),   32'(out_tdata[27:12]));
        check_field("changed",      32'(want_w.changed),      32'(out_tdata[28]));
        check_field("status",       32'(want_w.status),       32'(out_tdata[30:29]));
        check_field("pad",          0,                        32'(out_tdata[31]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: drop the run when no word moves for too long
  // ---------------------------------------------------------------------------
  int quiet_n = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_n <= 0;
    end else if (quiet_n >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_n <= quiet_n + 1;
    end
  end

endmodule

### sim.f
rtl/core/tts_pkg.sv
rtl/core/tts_ram.sv
rtl/core/tts_ctrl.sv
rtl/core/tts_datapath.sv
rtl/core/timed_turn_queue_scheduler.sv
tb/testbench.sv
